// ----- rtl/mdcs_pkg.sv -----
// mdcs_pkg: shared types and fixed field widths for the minimum distance corner selector
// used by mdcs_cell and min_distance_corner_selector; no dependencies
package mdcs_pkg;

    // fixed field widths of the streaming channels
    localparam int IN_COORD_W  = 12;
    localparam int SCORE_W     = 32;
    localparam int DIST_W      = 26;
    localparam int COUNT_W     = 11;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 72;
    localparam int M_TDATA_PAD = M_TDATA_W - (2 * IN_COORD_W + SCORE_W + COUNT_W);
    localparam int M_TUSER_W   = 2;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 26;

    localparam logic [CFG_ADDR_W-1:0] REG_SPACING_ON  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DIST_SQ = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_CORNERS = 2'd2;

    // register reset values
    localparam logic [DIST_W-1:0]  MIN_DIST_SQ_RST = 26'd100;
    localparam logic [COUNT_W-1:0] MAX_CORNERS_RST = 11'd0;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic scan_en;
        logic wr_en;
        logic clear;
    } cell_ctl_t;

endpackage

// ----- rtl/mdcs_cell.sv -----
// mdcs_cell: one cell of the kept-point chain, holding a slice of the point store
// depends on mdcs_pkg (cell_ctl_t, DIST_W)
module mdcs_cell #(
    parameter int SLICE = 32,
    parameter int CW    = 12,
    parameter int AW    = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mdcs_pkg::cell_ctl_t         ctl,
    input  logic [AW-1:0]               scan_addr,
    input  logic [AW-1:0]               wr_addr,
    input  logic [CW-1:0]               cand_x,
    input  logic [CW-1:0]               cand_y,
    input  logic [mdcs_pkg::DIST_W-1:0] min_dist_sq,
    input  logic                        near_in,
    output logic                        near_out
);

    localparam int FW = $clog2(SLICE + 1);
    localparam int SW = 2 * CW;
    localparam int DW = (SW + 1 > mdcs_pkg::DIST_W) ? SW + 1 : mdcs_pkg::DIST_W;

    logic [CW-1:0] mem_x [SLICE];
    logic [CW-1:0] mem_y [SLICE];

    logic [FW-1:0] fill_reg,  fill_next;
    logic [CW-1:0] rx_reg,    ry_reg;
    logic          rval_reg,  rval_next;
    logic [SW-1:0] sqx_reg,   sqx_next;
    logic [SW-1:0] sqy_reg,   sqy_next;
    logic          bval_reg;
    logic          near_reg,  near_next;
    logic [CW-1:0] dx,        dy;
    logic [DW-1:0] dist_sum;
    logic          hit;

    // slice storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem_x[wr_addr] <= cand_x;
            mem_y[wr_addr] <= cand_y;
        end
        rx_reg <= mem_x[scan_addr];
        ry_reg <= mem_y[scan_addr];
    end

    // fill count of this slice, emptied at frame end
    always_comb begin
        fill_next = fill_reg;
        if (ctl.clear) begin
            fill_next = '0;
        end else if (ctl.wr_en) begin
            fill_next = fill_reg + FW'(1);
        end
    end

    // entry read is live only below the fill count
    assign rval_next = ctl.scan_en && (FW'(scan_addr) < fill_reg);

    // absolute differences and squares
    always_comb begin
        dx       = (cand_x >= rx_reg) ? (cand_x - rx_reg) : (rx_reg - cand_x);
        dy       = (cand_y >= ry_reg) ? (cand_y - ry_reg) : (ry_reg - cand_y);
        sqx_next = SW'(dx) * SW'(dx);
        sqy_next = SW'(dy) * SW'(dy);
    end

    // distance compare and hand-off along the chain
    always_comb begin
        dist_sum  = DW'(sqx_reg) + DW'(sqy_reg);
        hit       = bval_reg && (dist_sum < DW'(min_dist_sq));
        near_next = near_in || hit;
    end

    always_ff @(posedge aclk) begin
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            rval_reg <= 1'b0;
            bval_reg <= 1'b0;
            near_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            rval_reg <= rval_next;
            bval_reg <= rval_reg;
            near_reg <= near_next;
        end
    end

    assign near_out = near_reg;

endmodule

// ----- rtl/min_distance_corner_selector.sv -----
// min_distance_corner_selector: greedy minimum distance suppression of sorted corners
// depends on mdcs_pkg and mdcs_cell
//
// Usage: candidates arrive on the s_axis channel sorted by descending score; each
// transaction gives exactly one result transaction on m_axis with keep, store_full,
// the echoed coordinates and score, and the running kept count. tlast marks the
// last candidate of a frame; after its result the point store is emptied.
// The store is a chain of NUM_CELLS cells, each holding a slice of
// ceil(MAX_POINTS / NUM_CELLS) points. All cells scan their slice in parallel, one
// entry per cycle, and the too-close flag ripples one cell per cycle to the end.
// With spacing on and a nonempty store an item passes through the slice scan and
// the flag ripple along the chain before its decide step; with spacing off, an empty
// store or the corner limit reached it goes from acceptance straight to the decide
// step. A new candidate is accepted only once the current one has committed.
// A finished result waits in the output register while the next candidate is
// accepted; if m_axis_tready stays low, the following result holds in the decide
// step and s_axis_tready stays low until the output register frees up.
// Reset is synchronous (aresetn low): the store is empty, spacing on, min_dist_sq
// 100, no corner limit. No clearing pass is needed after reset.
module min_distance_corner_selector #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 12,
    parameter int NUM_CELLS  = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // cand_x [11:0], cand_y [23:12], cand_score [55:24]
    input  logic [mdcs_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // out_x [11:0], out_y [23:12], out_score [55:24], kept_count [66:56], zeros above
    output logic [mdcs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // keep [0], store_full [1]
    output logic [mdcs_pkg::M_TUSER_W-1:0]      m_axis_tuser,
    output logic                                m_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_wr_en,
    input  logic [mdcs_pkg::CFG_ADDR_W-1:0]     cfg_wr_addr,
    input  logic [mdcs_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int IW       = mdcs_pkg::IN_COORD_W;
    localparam int CW       = (COORD_BITS < IW) ? COORD_BITS : IW;
    localparam int SLICE    = (MAX_POINTS + NUM_CELLS - 1) / NUM_CELLS;
    localparam int AW       = (SLICE > 1) ? $clog2(SLICE) : 1;
    localparam int CIW      = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int CMP_W    = (CNT_W > mdcs_pkg::COUNT_W) ? CNT_W : mdcs_pkg::COUNT_W;
    localparam int SCAN_LEN = SLICE + NUM_CELLS + 3;
    localparam int SCW      = $clog2(SCAN_LEN + 1);

    mdcs_pkg::state_t state_reg, state_next;

    // configuration registers
    logic                          spacing_on_reg;
    logic [mdcs_pkg::DIST_W-1:0]   min_dist_sq_reg;
    logic [mdcs_pkg::COUNT_W-1:0]  max_corners_reg;

    // candidate under test
    logic [CW-1:0]                 cx_reg, cy_reg;
    logic [mdcs_pkg::SCORE_W-1:0]  cscore_reg;
    logic                          clast_reg;

    logic [SCW-1:0]                cnt_reg, cnt_next;
    logic                          near_acc_reg, near_acc_next;
    logic [CNT_W-1:0]              kept_total_reg, kept_total_next;
    logic [AW-1:0]                 wr_addr_reg, wr_addr_next;
    logic [CIW-1:0]                wr_cell_reg, wr_cell_next;

    // result register
    logic                          m_valid_reg, m_valid_next;
    logic [IW-1:0]                 ox_reg, oy_reg;
    logic [mdcs_pkg::SCORE_W-1:0]  oscore_reg;
    logic [mdcs_pkg::COUNT_W-1:0]  okept_reg;
    logic                          okeep_reg, ofull_reg, olast_reg;

    logic                          s_acc;
    logic                          commit;
    logic                          scan_en;
    logic                          limit_hit;
    logic                          store_full;
    logic                          keep_d;
    logic                          full_d;
    logic [CNT_W-1:0]              total_after;
    logic [CMP_W-1:0]              total_after_ext;
    logic [AW-1:0]                 scan_addr;
    logic                          near_chain [NUM_CELLS+1];

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_on_reg  <= 1'b1;
            min_dist_sq_reg <= mdcs_pkg::MIN_DIST_SQ_RST;
            max_corners_reg <= mdcs_pkg::MAX_CORNERS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                mdcs_pkg::REG_SPACING_ON: begin
                    spacing_on_reg <= cfg_wr_data[0];
                end
                mdcs_pkg::REG_MIN_DIST_SQ: begin
                    min_dist_sq_reg <= cfg_wr_data[mdcs_pkg::DIST_W-1:0];
                end
                mdcs_pkg::REG_MAX_CORNERS: begin
                    max_corners_reg <= cfg_wr_data[mdcs_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // decision on the candidate from the store state
    always_comb begin
        limit_hit   = (max_corners_reg != '0) &&
                      (CMP_W'(kept_total_reg) >= CMP_W'(max_corners_reg));
        store_full  = (kept_total_reg >= CNT_W'(MAX_POINTS));
        keep_d      = !limit_hit && !(spacing_on_reg && near_acc_reg) && !store_full;
        full_d      = !limit_hit && !(spacing_on_reg && near_acc_reg) && store_full;
        total_after = keep_d ? (kept_total_reg + CNT_W'(1)) : kept_total_reg;
        total_after_ext = CMP_W'(total_after);
    end

    assign commit = (state_reg == mdcs_pkg::ST_DECIDE) && (!m_valid_reg || m_axis_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mdcs_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (!spacing_on_reg || (kept_total_reg == '0) || limit_hit) begin
                        state_next = mdcs_pkg::ST_DECIDE;
                    end else begin
                        state_next = mdcs_pkg::ST_SCAN;
                    end
                end
            end
            mdcs_pkg::ST_SCAN: begin
                if (cnt_reg == SCW'(SCAN_LEN - 1)) begin
                    state_next = mdcs_pkg::ST_DECIDE;
                end
            end
            mdcs_pkg::ST_DECIDE: begin
                if (commit) begin
                    state_next = mdcs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mdcs_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        scan_en       = 1'b0;
        case (state_reg)
            mdcs_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            mdcs_pkg::ST_SCAN: begin
                scan_en = (cnt_reg < SCW'(SLICE));
            end
            mdcs_pkg::ST_DECIDE: begin
            end
            default: begin
            end
        endcase
    end

    assign scan_addr = cnt_reg[AW-1:0];

    // scan counter and too-close accumulation
    always_comb begin
        cnt_next      = '0;
        near_acc_next = near_acc_reg;
        if (s_acc) begin
            near_acc_next = 1'b0;
        end else if (state_reg == mdcs_pkg::ST_SCAN) begin
            cnt_next      = cnt_reg + SCW'(1);
            near_acc_next = near_acc_reg || near_chain[NUM_CELLS];
        end
    end

    // store bookkeeping at commit
    always_comb begin
        kept_total_next = kept_total_reg;
        wr_addr_next    = wr_addr_reg;
        wr_cell_next    = wr_cell_reg;
        if (commit) begin
            if (clast_reg) begin
                kept_total_next = '0;
                wr_addr_next    = '0;
                wr_cell_next    = '0;
            end else if (keep_d) begin
                kept_total_next = total_after;
                if (wr_addr_reg == AW'(SLICE - 1)) begin
                    wr_addr_next = '0;
                    wr_cell_next = wr_cell_reg + CIW'(1);
                end else begin
                    wr_addr_next = wr_addr_reg + AW'(1);
                end
            end
        end
    end

    // output valid: loaded on commit, dropped when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mdcs_pkg::ST_IDLE;
            cnt_reg        <= '0;
            near_acc_reg   <= 1'b0;
            kept_total_reg <= '0;
            wr_addr_reg    <= '0;
            wr_cell_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            near_acc_reg   <= near_acc_next;
            kept_total_reg <= kept_total_next;
            wr_addr_reg    <= wr_addr_next;
            wr_cell_reg    <= wr_cell_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // candidate capture
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cx_reg     <= s_axis_tdata[CW-1:0];
            cy_reg     <= s_axis_tdata[IW+CW-1:IW];
            cscore_reg <= s_axis_tdata[2*IW+mdcs_pkg::SCORE_W-1:2*IW];
            clast_reg  <= s_axis_tlast;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (commit) begin
            ox_reg     <= IW'(cx_reg);
            oy_reg     <= IW'(cy_reg);
            oscore_reg <= cscore_reg;
            okept_reg  <= total_after_ext[mdcs_pkg::COUNT_W-1:0];
            okeep_reg  <= keep_d;
            ofull_reg  <= full_d;
            olast_reg  <= clast_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = {ofull_reg, okeep_reg};
    assign m_axis_tdata  = {{mdcs_pkg::M_TDATA_PAD{1'b0}}, okept_reg, oscore_reg,
                            oy_reg, ox_reg};

    // chain of store cells
    assign near_chain[0] = 1'b0;

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        mdcs_pkg::cell_ctl_t cell_ctl;

        always_comb begin
            cell_ctl.scan_en = scan_en;
            cell_ctl.wr_en   = commit && keep_d && (wr_cell_reg == CIW'(c));
            cell_ctl.clear   = commit && clast_reg;
        end

        mdcs_cell #(
            .SLICE (SLICE),
            .CW    (CW),
            .AW    (AW)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (cell_ctl),
            .scan_addr   (scan_addr),
            .wr_addr     (wr_addr_reg),
            .cand_x      (cx_reg),
            .cand_y      (cy_reg),
            .min_dist_sq (min_dist_sq_reg),
            .near_in     (near_chain[c]),
            .near_out    (near_chain[c+1])
        );
    end

    // store never holds more than its capacity
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_total_reg <= CNT_W'(MAX_POINTS))
        else $error("kept point total above store capacity");

    // write pointer tracks the kept total while the store has room
    a_wr_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (kept_total_reg < CNT_W'(MAX_POINTS)) |->
        ((32'(wr_cell_reg) * SLICE + 32'(wr_addr_reg)) == 32'(kept_total_reg)))
        else $error("store write pointer out of step with kept total");

    // a full-store rejection never keeps the candidate
    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[0])
        else $error("store_full flagged on a kept candidate");

    // with spacing off no scan is run
    a_no_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !spacing_on_reg) |=> (state_reg == mdcs_pkg::ST_DECIDE))
        else $error("scan started with spacing off");

endmodule
